// ===== hw/rtl/hbd_pkg.sv =====
package hbd_pkg;

  // Default sizing of the decoder
  localparam int unsigned TABLE_DEPTH_DEF  = 256;
  localparam int unsigned MAX_CODE_LEN_DEF = 32;

  // Request operations
  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_STREAM = 2'd1,
    OP_START  = 2'd2
  } hbd_op_e;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_SYMBOL   = 2'd0,
    KIND_OVERFLOW = 2'd1,
    KIND_FULL     = 2'd2
  } hbd_kind_e;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_BITS  = 2'd1,
    ST_FLUSH = 2'd2
  } hbd_state_e;

  // One code table entry
  typedef struct packed {
    logic [7:0]  symbol;
    logic [5:0]  length;
    logic [31:0] code;
  } hbd_entry_t;

  // Input request
  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  entry_symbol;
    logic [5:0]  entry_length;
    logic [31:0] entry_code;
    logic [7:0]  stream_byte;
    logic [3:0]  bits_used;
  } hbd_in_req_t;

  // Output request
  typedef struct packed {
    hbd_kind_e  kind;
    logic [7:0] decoded_symbol;
    logic       last;
  } hbd_out_req_t;

endpackage

// ===== hw/rtl/hbd_cell.sv =====
// One table cell: holds an entry, compares it against the broadcast key,
// and takes its left neighbor's entry when the table shifts on a load.
module hbd_cell import hbd_pkg::*; #(
  parameter int unsigned KeyLenW = 7,
  parameter int unsigned KeyValW = 32
) (
  input  logic               clk_i,
  input  logic               shift_i,
  input  hbd_entry_t         ent_i,
  input  logic               shadow_i,
  input  logic [KeyLenW-1:0] key_len_i,
  input  logic [KeyValW-1:0] key_val_i,
  output hbd_entry_t         ent_o,
  output logic               shadow_o,
  output logic               key_hit_o
);

  hbd_entry_t ent_q;
  logic       shadow_q;

  // Entry and shadow flag move one cell along whenever the table shifts on a load
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      ent_q    <= ent_i;
      shadow_q <= shadow_i;
    end
  end

  // Length and code must both agree with the key
  assign key_hit_o = (key_len_i == KeyLenW'(ent_q.length)) &&
                     (key_val_i == KeyValW'(ent_q.code));

  assign ent_o    = ent_q;
  assign shadow_o = shadow_q;

endmodule

// ===== hw/rtl/huffman_table_bit_decoder.sv =====
// Table-driven Huffman decoder. The code table is a row of TABLE_DEPTH cells;
// each load request shifts the row by one, the newest entry entering at cell
// zero, and marks as shadowed every older entry with the same length and code,
// so at most one live entry can ever match and the newest one wins. A start
// request empties the table and the prefix. A stream request is taken and
// then walks its bits_used bits (at most eight), one bit per cycle while no
// older result waits on a stalled output, appending each to the prefix and
// comparing the prefix against every cell at once; that one-bit-per-cycle
// prefix loop sets the rate. A byte's final result, when it has any, is handed
// out from the flush state, later while the output is stalled. A load that
// hits a full table reports it as its only result. Results leave through an
// output register; the final result of a request has last set.
module huffman_table_bit_decoder import hbd_pkg::*; #(
  parameter int unsigned TABLE_DEPTH  = TABLE_DEPTH_DEF,
  parameter int unsigned MAX_CODE_LEN = MAX_CODE_LEN_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  hbd_in_req_t  in_req_i,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output hbd_out_req_t out_req_o
);

  localparam int unsigned CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned PLEN_W = $clog2(MAX_CODE_LEN + 1);
  localparam int unsigned KLW    = (PLEN_W > 6) ? PLEN_W : 6;
  localparam int unsigned KVW    = (MAX_CODE_LEN > 32) ? MAX_CODE_LEN : 32;

  hbd_state_e state_q, state_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic [MAX_CODE_LEN-1:0] pval_q, pval_d;
  logic [PLEN_W-1:0]       plen_q, plen_d;
  logic [7:0]              byte_q, byte_d;
  logic [3:0]              left_q, left_d;
  logic                    pend_vld_q, pend_vld_d;
  hbd_kind_e               pend_kind_q, pend_kind_d;
  logic [7:0]              pend_sym_q, pend_sym_d;
  logic                    out_valid_q, out_valid_d;
  hbd_out_req_t            out_q, out_d;

  logic                    shift_en;
  logic                    full;
  logic                    out_free;
  logic                    overflow;
  logic [MAX_CODE_LEN-1:0] nv;
  logic [PLEN_W-1:0]       nl;
  logic [KLW-1:0]          key_len;
  logic [KVW-1:0]          key_val;
  hbd_entry_t              new_ent;

  hbd_entry_t       ent      [TABLE_DEPTH];
  logic             shadow   [TABLE_DEPTH];
  logic             key_hit  [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] match;
  logic             hit_any;
  logic [7:0]       hit_sym;

  assign full     = (cnt_q == CNT_W'(TABLE_DEPTH));
  assign out_free = !out_valid_q || !out_stall_i;

  // Next prefix with the current byte's leading bit appended
  assign nv       = {pval_q[MAX_CODE_LEN-2:0], byte_q[7]};
  assign nl       = plen_q + PLEN_W'(1);
  assign overflow = (plen_q == PLEN_W'(MAX_CODE_LEN));

  assign new_ent.symbol = in_req_i.entry_symbol;
  assign new_ent.length = in_req_i.entry_length;
  assign new_ent.code   = in_req_i.entry_code;

  // Broadcast key: the entry being loaded while idle, else the grown prefix
  always_comb begin
    if (state_q == ST_IDLE) begin
      key_len = KLW'(in_req_i.entry_length);
      key_val = KVW'(in_req_i.entry_code);
    end else begin
      key_len = KLW'(nl);
      key_val = KVW'(nv);
    end
  end

  // Row of table cells
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      hbd_cell #(
        .KeyLenW (KLW),
        .KeyValW (KVW)
      ) u_cell (
        .clk_i     (clk_i),
        .shift_i   (shift_en),
        .ent_i     (new_ent),
        .shadow_i  (1'b0),
        .key_len_i (key_len),
        .key_val_i (key_val),
        .ent_o     (ent[i]),
        .shadow_o  (shadow[i]),
        .key_hit_o (key_hit[i])
      );
    end else begin : g_body
      hbd_cell #(
        .KeyLenW (KLW),
        .KeyValW (KVW)
      ) u_cell (
        .clk_i     (clk_i),
        .shift_i   (shift_en),
        .ent_i     (ent[i-1]),
        .shadow_i  (shadow[i-1] | key_hit[i-1]),
        .key_len_i (key_len),
        .key_val_i (key_val),
        .ent_o     (ent[i]),
        .shadow_o  (shadow[i]),
        .key_hit_o (key_hit[i])
      );
    end
    // Only occupied, unshadowed cells take part in decoding
    assign match[i] = (cnt_q > CNT_W'(i)) && !shadow[i] && key_hit[i];
  end

  // Matches are one-hot, so the symbol is a plain AND-OR select
  always_comb begin
    hit_sym = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      hit_sym = hit_sym | (match[i] ? ent[i].symbol : 8'd0);
    end
  end
  assign hit_any = |match;

  // Sequencer and datapath next state
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    pval_d      = pval_q;
    plen_d      = plen_q;
    byte_d      = byte_q;
    left_d      = left_q;
    pend_vld_d  = pend_vld_q;
    pend_kind_d = pend_kind_q;
    pend_sym_d  = pend_sym_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    shift_en    = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (in_req_i.op)
            OP_LOAD: begin
              if (full) begin
                pend_vld_d  = 1'b1;
                pend_kind_d = KIND_FULL;
                pend_sym_d  = '0;
                state_d     = ST_FLUSH;
              end else begin
                shift_en = 1'b1;
                cnt_d    = cnt_q + CNT_W'(1);
              end
            end
            OP_STREAM: begin
              byte_d = in_req_i.stream_byte;
              left_d = (in_req_i.bits_used > 4'd8) ? 4'd8 : in_req_i.bits_used;
              if (in_req_i.bits_used != 4'd0) begin
                state_d = ST_BITS;
              end
            end
            OP_START: begin
              cnt_d  = '0;
              pval_d = '0;
              plen_d = '0;
            end
            default: ;
          endcase
        end
      end

      ST_BITS: begin
        // A new result needs room only when an older one is still held back
        if (!pend_vld_q || out_free) begin
          byte_d = {byte_q[6:0], 1'b0};
          left_d = left_q - 4'd1;
          if (overflow || hit_any) begin
            if (pend_vld_q) begin
              out_valid_d          = 1'b1;
              out_d.kind           = pend_kind_q;
              out_d.decoded_symbol = pend_sym_q;
              out_d.last           = 1'b0;
            end
            pend_vld_d  = 1'b1;
            pend_kind_d = overflow ? KIND_OVERFLOW : KIND_SYMBOL;
            pend_sym_d  = overflow ? 8'd0 : hit_sym;
            pval_d      = '0;
            plen_d      = '0;
          end else begin
            pval_d = nv;
            plen_d = nl;
          end
          if (left_q == 4'd1) begin
            state_d = (overflow || hit_any || pend_vld_q) ? ST_FLUSH : ST_IDLE;
          end
        end
      end

      ST_FLUSH: begin
        // Final result of the request
        if (out_free) begin
          out_valid_d          = 1'b1;
          out_d.kind           = pend_kind_q;
          out_d.decoded_symbol = pend_sym_q;
          out_d.last           = 1'b1;
          pend_vld_d           = 1'b0;
          state_d              = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      pval_q      <= '0;
      plen_q      <= '0;
      left_q      <= '0;
      pend_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pval_q      <= pval_d;
      plen_q      <= plen_d;
      left_q      <= left_d;
      pend_vld_q  <= pend_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    byte_q      <= byte_d;
    pend_kind_q <= pend_kind_d;
    pend_sym_q  <= pend_sym_d;
    out_q       <= out_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  // Shadowing on load must leave at most one live matching entry
  a_match_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(match))
    else $error("more than one live table entry matches");

  a_prefix_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    plen_q <= PLEN_W'(MAX_CODE_LEN))
    else $error("prefix longer than maximum code length");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !pend_vld_q)
    else $error("result left pending after request finished");

endmodule

// ===== sim/huffman_table_bit_decoder_test.sv =====
`timescale 1ns / 1ps

module huffman_table_bit_decoder_test;
  import hbd_pkg::*;

  localparam int unsigned TABLE_DEPTH  = TABLE_DEPTH_DEF;
  localparam int unsigned MAX_CODE_LEN = MAX_CODE_LEN_DEF;
  localparam logic [1:0]  OP_UNUSED    = 2'd3;
  localparam int RANDOM_ITEMS = 90;
  localparam int IDLE_PCT     = 21;
  localparam int QUIET_LO     = 1500;
  localparam int QUIET_HI     = 3500;
  localparam int HOLD_AT      = 80;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 32;
  localparam int CYCLE_LIMIT  = 500000;

  logic         clk_i       = 1'b0;
  logic         rst_ni      = 1'b0;
  logic         in_valid_i  = 1'b0;
  logic         in_stall_o;
  hbd_in_req_t  in_req_i    = '0;
  logic         out_valid_o;
  logic         out_stall_i = 1'b0;
  hbd_out_req_t out_req_o;

  huffman_table_bit_decoder #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .MAX_CODE_LEN(MAX_CODE_LEN)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_req_o  (out_req_o)
  );

  always #4 clk_i = ~clk_i;

  // Requests waiting to be driven, results still owed by the decoder
  hbd_in_req_t  pending_reqs[$];
  hbd_out_req_t results_due[$];

  // Decoder state as the testbench tracks it
  logic [7:0]  tbl_symbol[TABLE_DEPTH];
  logic [5:0]  tbl_length[TABLE_DEPTH];
  logic [31:0] tbl_code[TABLE_DEPTH];
  int          tbl_count = 0;
  logic [63:0] pfx_value = '0;
  int          pfx_len   = 0;

  int cyc          = 0;
  int stim_count   = 0;
  int req_accepted = 0;
  int mismatches   = 0;
  int hold_left    = 0;
  bit hold_used    = 1'b0;

  function automatic void add_due(hbd_kind_e kind, logic [7:0] sym);
    hbd_out_req_t res;
    res.kind           = kind;
    res.decoded_symbol = sym;
    res.last           = 1'b0;
    results_due = {results_due, res};
  endfunction

  // Work out the results one accepted request causes
  function automatic void decode_request(hbd_in_req_t r);
    int   base;
    int   used;
    int   b;
    int   i;
    bit   hit;
    logic [7:0] hit_sym;
    base = results_due.size();
    case (r.op)
      OP_LOAD: begin
        if (tbl_count >= TABLE_DEPTH) begin
          add_due(KIND_FULL, 8'h00);
        end else begin
          tbl_symbol[tbl_count] = r.entry_symbol;
          tbl_length[tbl_count] = r.entry_length;
          tbl_code[tbl_count]   = r.entry_code;
          tbl_count++;
        end
      end
      OP_STREAM: begin
        used = (r.bits_used > 4'd8) ? 8 : int'(r.bits_used);
        for (b = 0; b < used; b++) begin
          pfx_value = {pfx_value[62:0], r.stream_byte[7-b]};
          pfx_len++;
          if (pfx_len > MAX_CODE_LEN) begin
            add_due(KIND_OVERFLOW, 8'h00);
            pfx_value = '0;
            pfx_len   = 0;
          end else begin
            // newest entry wins among equal codes
            hit     = 1'b0;
            hit_sym = '0;
            for (i = tbl_count - 1; i >= 0 && !hit; i--) begin
              if (int'(tbl_length[i]) == pfx_len && {32'd0, tbl_code[i]} == pfx_value) begin
                hit     = 1'b1;
                hit_sym = tbl_symbol[i];
              end
            end
            if (hit) begin
              add_due(KIND_SYMBOL, hit_sym);
              pfx_value = '0;
              pfx_len   = 0;
            end
          end
        end
      end
      OP_START: begin
        tbl_count = 0;
        pfx_value = '0;
        pfx_len   = 0;
      end
      default: ;
    endcase
    if (results_due.size() > base) results_due[results_due.size()-1].last = 1'b1;
  endfunction

  function automatic void check_result(hbd_out_req_t got);
    hbd_out_req_t want;
    if (results_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: kind %0d symbol %02h last %0b",
                 got.kind, got.decoded_symbol, got.last);
    end else begin
      want = results_due.pop_front();
      if (got.kind !== want.kind || got.decoded_symbol !== want.decoded_symbol ||
          got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected kind %0d symbol %02h last %0b, ",
                   want.kind, want.decoded_symbol, want.last,
                   "got kind %0d symbol %02h last %0b",
                   got.kind, got.decoded_symbol, got.last);
      end
    end
  endfunction

  function automatic bit take_break();
    return (cyc < QUIET_LO || cyc >= QUIET_HI) && ($urandom_range(99) < IDLE_PCT);
  endfunction

  // Stimulus helpers: unused fields carry random noise
  function automatic hbd_in_req_t rand_req();
    logic [63:0] raw;
    raw = {$urandom(), $urandom()};
    return raw[59:0];
  endfunction

  function automatic void add_req(hbd_in_req_t r);
    pending_reqs = {pending_reqs, r};
    if (!(r.op == OP_UNUSED || (r.op == OP_STREAM && r.bits_used == 4'd0))) stim_count++;
  endfunction

  function automatic void add_start();
    hbd_in_req_t r;
    r    = rand_req();
    r.op = OP_START;
    add_req(r);
  endfunction

  function automatic void add_load(logic [7:0] sym, logic [5:0] len, logic [31:0] code);
    hbd_in_req_t r;
    r              = rand_req();
    r.op           = OP_LOAD;
    r.entry_symbol = sym;
    r.entry_length = len;
    r.entry_code   = code;
    add_req(r);
  endfunction

  function automatic void add_stream(logic [7:0] data, logic [3:0] used);
    hbd_in_req_t r;
    r             = rand_req();
    r.op          = OP_STREAM;
    r.stream_byte = data;
    r.bits_used   = used;
    add_req(r);
  endfunction

  // Request driver; predicts on every accepted request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        decode_request(in_req_i);
        req_accepted++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_reqs.size() != 0 && !take_break()) begin
          in_valid_i <= 1'b1;
          in_req_i   <= pending_reqs.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result stall: random, plus one long hold-off to back up the decoder
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else if (!hold_used && req_accepted >= HOLD_AT) begin
      hold_used = 1'b1;
      hold_left = HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= take_break();
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) check_result(out_req_o);
  end

  // Watchdog
  always @(posedge clk_i) begin
    cyc++;
    if (cyc >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    hbd_in_req_t r;
    logic [31:0] leaf_code[$];
    int          leaf_len[$];
    logic [7:0]  leaf_sym[$];
    bit          bits_q[$];
    logic [31:0] c;
    logic [7:0]  data;
    int          l;
    int          n;
    int          k;
    int          pick;
    int          depth;
    int          used;
    int          last_i;
    bit          deep;

    // Directed: empty table lets the prefix grow to the limit, then overflow
    add_start();
    add_stream(8'hA5, 4'd8);
    repeat (3) add_stream(8'hFF, 4'd8);
    add_stream(8'h80, 4'd1);
    r    = rand_req();
    r.op = OP_UNUSED;
    add_req(r);
    add_stream(8'h3C, 4'd0);
    // one-bit codes: eight symbols per byte, zero-length entry, shadowed entry
    add_start();
    add_load(8'h11, 6'd1, 32'h0000_0000);
    add_load(8'h22, 6'd1, 32'h0000_0001);
    add_load(8'h33, 6'd0, 32'h0000_0000);
    add_load(8'h44, 6'd1, 32'h0000_0001);
    add_stream(8'h5A, 4'd8);
    add_stream(8'h0F, 4'd15);
    // longest legal code, plus codes too long to ever match
    add_start();
    add_load(8'hFF, 6'd32, 32'hFFFF_FFFF);
    add_load(8'h00, 6'd33, 32'h0000_0000);
    add_load(8'h00, 6'd63, 32'hFFFF_FFFF);
    repeat (4) add_stream(8'hFF, 4'd8);
    add_stream(8'h00, 4'd7);

    // Random: mostly prefix-free tables with streams built from their codes
    stim_count = 0;
    while (stim_count < RANDOM_ITEMS) begin
      if ($urandom_range(99) < 75) begin
        add_start();
        leaf_code.delete();
        leaf_len.delete();
        leaf_sym.delete();
        leaf_code = {leaf_code, 32'd0};
        leaf_code = {leaf_code, 32'd1};
        leaf_len  = {leaf_len, 1};
        leaf_len  = {leaf_len, 1};
        deep = ($urandom_range(19) == 0);
        if (deep) begin
          // chain of splits down to a long code
          depth = $urandom_range(20, MAX_CODE_LEN);
          last_i = 1;
          while (leaf_len[last_i] < depth) begin
            c = leaf_code[last_i];
            l = leaf_len[last_i];
            leaf_code[last_i] = c << 1;
            leaf_len[last_i]  = l + 1;
            leaf_code = {leaf_code, (c << 1) | 32'd1};
            leaf_len  = {leaf_len, l + 1};
            last_i = leaf_code.size() - 1;
          end
        end else begin
          n = $urandom_range(2, 16);
          while (leaf_code.size() < n) begin
            pick = $urandom_range(leaf_code.size() - 1);
            if (leaf_len[pick] < 10) begin
              c = leaf_code[pick];
              l = leaf_len[pick];
              leaf_code[pick] = c << 1;
              leaf_len[pick]  = l + 1;
              leaf_code = {leaf_code, (c << 1) | 32'd1};
              leaf_len  = {leaf_len, l + 1};
            end
          end
        end
        foreach (leaf_code[i]) begin
          leaf_sym = {leaf_sym, 8'($urandom_range(255))};
          add_load(leaf_sym[i], 6'(leaf_len[i]), leaf_code[i]);
        end
        // occasional decoy: shadowing duplicate, zero length, or overlong code
        if ($urandom_range(4) == 0) begin
          case ($urandom_range(2))
            0: begin
              pick = $urandom_range(leaf_code.size() - 1);
              add_load(8'($urandom_range(255)), 6'(leaf_len[pick]), leaf_code[pick]);
            end
            1: add_load(8'($urandom_range(255)), 6'd0, $urandom());
            default: add_load(8'($urandom_range(255)), 6'($urandom_range(33, 63)), $urandom());
          endcase
        end
        bits_q.delete();
        k = deep ? $urandom_range(1, 4) : $urandom_range(1, 24);
        repeat (k) begin
          pick = $urandom_range(leaf_code.size() - 1);
          for (int j = leaf_len[pick] - 1; j >= 0; j--) bits_q = {bits_q, leaf_code[pick][j]};
        end
        if ($urandom_range(9) == 0)
          repeat ($urandom_range(1, 12)) bits_q = {bits_q, 1'($urandom_range(1))};
        // pack MSB first; padding bits of the last byte are random
        while (bits_q.size() != 0) begin
          data = 8'($urandom_range(255));
          used = (bits_q.size() < 8) ? bits_q.size() : 8;
          for (int j = 0; j < used; j++) data[7-j] = bits_q.pop_front();
          if (used == 8 && $urandom_range(6) == 0) used = $urandom_range(9, 15);
          add_stream(data, 4'(used));
          if ($urandom_range(19) == 0) add_stream(8'($urandom_range(255)), 4'd0);
        end
      end else begin
        // noise: any op, any field values
        r = rand_req();
        if (r.op == OP_LOAD && $urandom_range(1) == 1) begin
          r.entry_length = 6'($urandom_range(1, 8));
          r.entry_code   = 32'($urandom_range(255)) >> (8 - r.entry_length);
        end
        add_req(r);
      end
    end

    // Fill the table, overrun it, then decode against all entries
    add_start();
    repeat (TABLE_DEPTH + 3) begin
      l = $urandom_range(1, 8);
      add_load(8'($urandom_range(255)), 6'(l), 32'($urandom_range((1 << l) - 1)));
    end
    repeat (6) add_stream(8'($urandom_range(255)), 4'd8);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i); while (pending_reqs.size() != 0 || in_valid_i);
    while (results_due.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (mismatches == 0 && results_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
